### hdl/plb_pkg.sv
// ----------------------------------------------------------------------------
// plb_pkg
// Shared widths, operation and status codes for the positional list buffer.
// ----------------------------------------------------------------------------
package plb_pkg;

  localparam int unsigned ListDepthDef = 64;
  localparam int unsigned DataW        = 32;
  localparam int unsigned PosW         = 16;
  localparam int unsigned OpW          = 3;
  localparam int unsigned StW          = 3;
  localparam int unsigned IdxW         = 6;
  localparam int unsigned CntW         = 7;

  typedef enum logic [OpW-1:0] {
    OP_LOAD   = 3'd0,
    OP_SHOW   = 3'd1,
    OP_INSERT = 3'd2,
    OP_UPDATE = 3'd3,
    OP_DELETE = 3'd4
  } op_e;

  typedef enum logic [StW-1:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_FULL   = 3'd2,
    ST_BADPOS = 3'd3,
    ST_BADCNT = 3'd4
  } status_e;

  typedef struct packed {
    logic            busy;
    logic [CntW-1:0] fill;
  } seq_stat_t;

endpackage

### hdl/plb_if.sv
// ----------------------------------------------------------------------------
// plb_in_if / plb_out_if
// Valid/ready channels carrying command items and result items.
// ----------------------------------------------------------------------------
interface plb_in_if;
  import plb_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [OpW-1:0]         operation;
  logic signed [DataW-1:0] item_value;
  logic signed [PosW-1:0] position;
  logic                   load_last;

  modport source (output valid, operation, item_value, position, load_last, input ready);
  modport sink   (input valid, operation, item_value, position, load_last, output ready);
endinterface

interface plb_out_if;
  import plb_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [StW-1:0]          status;
  logic signed [DataW-1:0] element_value;
  logic [IdxW-1:0]         element_index;
  logic [CntW-1:0]         element_count;
  logic                    last_result;

  modport source (output valid, status, element_value, element_index, element_count,
                  last_result, input ready);
  modport sink   (input valid, status, element_value, element_index, element_count,
                  last_result, output ready);
endinterface

### hdl/positional_list_buffer_core.sv
// ----------------------------------------------------------------------------
// positional_list_buffer_core
// Ordered list of signed 32-bit values edited by position, kept in one RAM.
// ----------------------------------------------------------------------------
//  channel | dir | handshake    | payload
//  in_i    | in  | valid/ready  | operation, item_value, position, load_last
//  out_o   | out | valid/ready  | status, element_value, element_index,
//          |     |              | element_count, last_result
//
//  One item at a time. Accepted load and update items write the RAM once;
//  show reads and emits each stored element in turn; insert and delete shift
//  the elements behind the position, as each move is a RAM read followed
//  by a write. Rejected items touch no RAM and go straight to a result.
//  Reset clears the counts; RAM contents are undefined until written.
//  A stalled output holds the sequencer; the next item is taken once the
//  last result is in the output register.
// ----------------------------------------------------------------------------
module positional_list_buffer_core #(
  parameter int unsigned LIST_DEPTH = plb_pkg::ListDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  plb_in_if.sink    in_i,
  plb_out_if.source out_o
);
  import plb_pkg::*;

  localparam int unsigned AW = $clog2(LIST_DEPTH);

  logic             wr_en, rd_en;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic [DataW-1:0] wr_data, rd_data;
  seq_stat_t        stat;

  plb_seq #(
    .ListDepth(LIST_DEPTH)
  ) u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .out_o    (out_o),
    .wr_en_o  (wr_en),
    .wr_addr_o(wr_addr),
    .wr_data_o(wr_data),
    .rd_en_o  (rd_en),
    .rd_addr_o(rd_addr),
    .rd_data_i(rd_data),
    .stat_o   (stat)
  );

  plb_mem #(
    .Depth(LIST_DEPTH)
  ) u_mem (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  // a shift step never reads and writes the RAM in the same cycle
  a_no_rw_same_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en && rd_en))
    else $error("RAM read and write in the same cycle");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.fill <= CntW'(LIST_DEPTH))
    else $error("fill count above list depth");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (stat.busy && !in_i.ready))
    else $error("item accepted while sequencer idle");

  a_no_ram_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stat.busy |-> (!wr_en && !rd_en))
    else $error("RAM access with no item in progress");

endmodule

### hdl/plb_mem.sv
// ----------------------------------------------------------------------------
// plb_mem
// Element store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module plb_mem #(
  parameter int unsigned Depth = plb_pkg::ListDepthDef,
  localparam int unsigned AW   = $clog2(Depth)
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [AW-1:0]            wr_addr_i,
  input  logic [plb_pkg::DataW-1:0] wr_data_i,
  input  logic                     rd_en_i,
  input  logic [AW-1:0]            rd_addr_i,
  output logic [plb_pkg::DataW-1:0] rd_data_o
);
  import plb_pkg::*;

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### hdl/plb_seq.sv
// ----------------------------------------------------------------------------
// plb_seq
// Command sequencer: decodes items, walks the store for show, insert and
// delete, keeps fill and load counts and owns the result register.
// ----------------------------------------------------------------------------
module plb_seq #(
  parameter int unsigned ListDepth = plb_pkg::ListDepthDef,
  localparam int unsigned AW       = $clog2(ListDepth)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  plb_in_if.sink                    in_i,
  plb_out_if.source                 out_o,
  output logic                      wr_en_o,
  output logic [AW-1:0]             wr_addr_o,
  output logic [plb_pkg::DataW-1:0] wr_data_o,
  output logic                      rd_en_o,
  output logic [AW-1:0]             rd_addr_o,
  input  logic [plb_pkg::DataW-1:0] rd_data_i,
  output plb_pkg::seq_stat_t        stat_o
);
  import plb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_SHOW_RD,
    S_SHOW_EMIT,
    S_INS_LOOP,
    S_INS_WR,
    S_DEL_LOOP,
    S_DEL_WR,
    S_RESP
  } state_e;

  localparam logic [CntW-1:0] DepthC = CntW'(ListDepth);

  state_e          state_q;
  logic [CntW-1:0] fill_q, load_q, i_q, p_q;
  logic [OpW-1:0]  op_q;
  logic [DataW-1:0] val_q;
  logic [PosW-1:0] pos_q;
  logic            last_q;
  status_e         res_stat_q;
  logic [IdxW-1:0] res_idx_q;

  logic            out_valid_q;
  logic [StW-1:0]  out_stat_q;
  logic [DataW-1:0] out_val_q;
  logic [IdxW-1:0] out_idx_q;
  logic [CntW-1:0] out_cnt_q;
  logic            out_last_q;

  logic            slot_free, pos_in_range, load_room, ins_more, del_more, emit;
  logic [CntW-1:0] i_inc, i_dec, ins_pos, load_inc;

  assign slot_free    = !out_valid_q || out_o.ready;
  // result register is loaded this cycle
  assign emit         = slot_free && ((state_q == S_SHOW_EMIT) || (state_q == S_RESP));
  // position is inside 0..fill-1 (fill never exceeds the depth)
  assign pos_in_range = !pos_q[PosW-1] && (pos_q[PosW-2:0] < (PosW-1)'(fill_q));
  assign load_room    = load_q < DepthC;
  assign i_inc        = i_q + CntW'(1);
  assign i_dec        = i_q - CntW'(1);
  assign load_inc     = load_q + CntW'(1);
  assign ins_more     = i_q > p_q;
  assign del_more     = i_inc < fill_q;

  always_comb begin
    if (pos_q[PosW-1]) begin
      ins_pos = '0;
    end else if (pos_q[PosW-2:0] > (PosW-1)'(fill_q)) begin
      ins_pos = fill_q;
    end else begin
      ins_pos = pos_q[CntW-1:0];
    end
  end

  // store port control
  always_comb begin
    wr_en_o   = 1'b0;
    wr_addr_o = i_q[AW-1:0];
    wr_data_o = val_q;
    rd_en_o   = 1'b0;
    rd_addr_o = i_q[AW-1:0];
    case (state_q)
      S_EXEC: begin
        if (op_q == OP_LOAD && load_room) begin
          wr_en_o   = 1'b1;
          wr_addr_o = load_q[AW-1:0];
        end else if (op_q == OP_UPDATE && pos_in_range) begin
          wr_en_o   = 1'b1;
          wr_addr_o = pos_q[AW-1:0];
        end
      end
      S_SHOW_RD: begin
        rd_en_o = 1'b1;
      end
      S_INS_LOOP: begin
        if (ins_more) begin
          rd_en_o   = 1'b1;
          rd_addr_o = i_dec[AW-1:0];
        end else begin
          wr_en_o   = 1'b1;
          wr_addr_o = p_q[AW-1:0];
        end
      end
      S_INS_WR, S_DEL_WR: begin
        wr_en_o   = 1'b1;
        wr_data_o = rd_data_i;
      end
      S_DEL_LOOP: begin
        if (del_more) begin
          rd_en_o   = 1'b1;
          rd_addr_o = i_inc[AW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      load_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            op_q    <= in_i.operation;
            val_q   <= in_i.item_value;
            pos_q   <= in_i.position;
            last_q  <= in_i.load_last;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (op_q)
            OP_LOAD: begin
              state_q <= S_RESP;
              if (load_room) begin
                res_stat_q <= ST_OK;
                res_idx_q  <= IdxW'(load_q);
                if (last_q) begin
                  fill_q <= load_inc;
                  load_q <= '0;
                end else begin
                  load_q <= load_inc;
                end
              end else begin
                res_stat_q <= ST_BADCNT;
                res_idx_q  <= '0;
                if (last_q) begin
                  load_q <= '0;
                end
              end
            end
            OP_SHOW: begin
              if (fill_q == '0) begin
                res_stat_q <= ST_EMPTY;
                res_idx_q  <= '0;
                state_q    <= S_RESP;
              end else begin
                i_q     <= '0;
                state_q <= S_SHOW_RD;
              end
            end
            OP_INSERT: begin
              if (fill_q >= DepthC) begin
                res_stat_q <= ST_FULL;
                res_idx_q  <= '0;
                state_q    <= S_RESP;
              end else begin
                p_q     <= ins_pos;
                i_q     <= fill_q;
                state_q <= S_INS_LOOP;
              end
            end
            OP_UPDATE: begin
              state_q <= S_RESP;
              if (pos_in_range) begin
                res_stat_q <= ST_OK;
                res_idx_q  <= IdxW'(pos_q[CntW-1:0]);
              end else begin
                res_stat_q <= ST_BADPOS;
                res_idx_q  <= '0;
              end
            end
            OP_DELETE: begin
              if (fill_q == '0) begin
                res_stat_q <= ST_EMPTY;
                res_idx_q  <= '0;
                state_q    <= S_RESP;
              end else if (!pos_in_range) begin
                res_stat_q <= ST_BADPOS;
                res_idx_q  <= '0;
                state_q    <= S_RESP;
              end else begin
                p_q     <= pos_q[CntW-1:0];
                i_q     <= pos_q[CntW-1:0];
                state_q <= S_DEL_LOOP;
              end
            end
            default: begin
              state_q <= S_IDLE;
            end
          endcase
        end
        S_SHOW_RD: begin
          state_q <= S_SHOW_EMIT;
        end
        S_SHOW_EMIT: begin
          if (slot_free) begin
            out_stat_q  <= ST_OK;
            out_val_q   <= rd_data_i;
            out_idx_q   <= IdxW'(i_q);
            out_cnt_q   <= fill_q;
            out_last_q  <= (i_inc == fill_q);
            i_q         <= i_inc;
            state_q     <= (i_inc == fill_q) ? S_IDLE : S_SHOW_RD;
          end
        end
        S_INS_LOOP: begin
          if (ins_more) begin
            state_q <= S_INS_WR;
          end else begin
            fill_q     <= fill_q + CntW'(1);
            res_stat_q <= ST_OK;
            res_idx_q  <= IdxW'(p_q);
            state_q    <= S_RESP;
          end
        end
        S_INS_WR: begin
          i_q     <= i_dec;
          state_q <= S_INS_LOOP;
        end
        S_DEL_LOOP: begin
          if (del_more) begin
            state_q <= S_DEL_WR;
          end else begin
            fill_q     <= fill_q - CntW'(1);
            res_stat_q <= ST_OK;
            res_idx_q  <= IdxW'(p_q);
            state_q    <= S_RESP;
          end
        end
        S_DEL_WR: begin
          i_q     <= i_inc;
          state_q <= S_DEL_LOOP;
        end
        S_RESP: begin
          if (slot_free) begin
            out_stat_q  <= res_stat_q;
            out_val_q   <= '0;
            out_idx_q   <= res_idx_q;
            out_cnt_q   <= fill_q;
            out_last_q  <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_i.ready          = (state_q == S_IDLE);
  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_stat_q;
  assign out_o.element_value = out_val_q;
  assign out_o.element_index = out_idx_q;
  assign out_o.element_count = out_cnt_q;
  assign out_o.last_result   = out_last_q;

  assign stat_o.busy = (state_q != S_IDLE);
  assign stat_o.fill = fill_q;

endmodule
